@@ sv/fbws_pkg.sv @@
// fbws_pkg: types, codes and constants shared by the flash block wear statistics block
// used by fbws_ctrl, fbws_dp, flash_block_wear_statistics and fbws_checker
`default_nettype none

package fbws_pkg;

	localparam int DEF_MAX_BLOCKS = 4096;

	localparam int STATE_W = 3;
	localparam int ERASE_W = 32;
	localparam int CNT_W   = 13;
	localparam int SUM_W   = 44;

	localparam logic [ERASE_W-1:0] THR_RESET = ERASE_W'(4096);

	localparam logic [STATE_W-1:0] BS_FREE    = 3'd0;
	localparam logic [STATE_W-1:0] BS_UNKNOWN = 3'd1;
	localparam logic [STATE_W-1:0] BS_RECLAIM = 3'd2;
	localparam logic [STATE_W-1:0] BS_BAD     = 3'd3;
	localparam logic [STATE_W-1:0] BS_WORN    = 3'd4;
	localparam logic [STATE_W-1:0] BS_CORRUPT = 3'd5;
	localparam logic [STATE_W-1:0] BS_MAPPED  = 3'd6;
	localparam logic [STATE_W-1:0] BS_INVALID = 3'd7;

	typedef enum logic [1:0] {
		S_LOAD,
		S_SCAN,
		S_FLUSH,
		S_PUBLISH
	} fbws_state_t;

	typedef struct packed {
		logic take;
		logic scan_rd;
		logic publish;
	} fbws_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic out_busy;
	} fbws_status_t;

endpackage

`default_nettype wire

@@ sv/fbws_ctrl.sv @@
// fbws_ctrl: sequencer for table load, relocation scan and result hand-off
// depends on fbws_pkg; drives the command struct of fbws_dp
`default_nettype none

module fbws_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   last_block,
	output logic                  in_stall,
	input  fbws_pkg::fbws_status_t status,
	output fbws_pkg::fbws_cmd_t    cmd
);
	import fbws_pkg::*;

	fbws_state_t state_q;
	fbws_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid && last_block) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.scan_end) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_nxt = S_PUBLISH;
			end
			S_PUBLISH: begin
				if (!status.out_busy) begin
					state_nxt = S_LOAD;
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.take    = 1'b0;
		cmd.scan_rd = 1'b0;
		cmd.publish = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
			end
			S_FLUSH: begin
			end
			S_PUBLISH: begin
				cmd.publish = !status.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/fbws_dp.sv @@
// fbws_dp: accumulators, block store memory, relocation scan and output register
// depends on fbws_pkg; commanded by fbws_ctrl
`default_nettype none

module fbws_dp #(
	parameter int MAX_BLOCKS = fbws_pkg::DEF_MAX_BLOCKS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  fbws_pkg::fbws_cmd_t                 cmd,
	output fbws_pkg::fbws_status_t              status,
	input  wire                                cfg_we,
	input  wire [fbws_pkg::ERASE_W-1:0]        cfg_thr,
	input  wire [fbws_pkg::STATE_W-1:0]        block_state,
	input  wire [fbws_pkg::ERASE_W-1:0]        erase_cnt,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [fbws_pkg::CNT_W-1:0]         free_count,
	output logic [fbws_pkg::CNT_W-1:0]         reclaimable_count,
	output logic [fbws_pkg::CNT_W-1:0]         bad_count,
	output logic [fbws_pkg::CNT_W-1:0]         corrupt_count,
	output logic [fbws_pkg::CNT_W-1:0]         healthy_count,
	output logic [fbws_pkg::CNT_W-1:0]         relocatable_count,
	output logic [fbws_pkg::SUM_W-1:0]         total_erase,
	output logic [fbws_pkg::ERASE_W-1:0]       min_erase,
	output logic [fbws_pkg::ERASE_W-1:0]       max_erase,
	output logic                               fault
);
	import fbws_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS + 1);
	localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(MAX_BLOCKS);

	logic [ERASE_W:0]   mem [MAX_BLOCKS];
	logic [ERASE_W:0]   rd_data_s1;
	logic               rd_vld_s1;

	logic [ERASE_W-1:0] thr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   scan_addr_q;
	logic [CNT_W-1:0]   free_q;
	logic [CNT_W-1:0]   reclaim_q;
	logic [CNT_W-1:0]   bad_q;
	logic [CNT_W-1:0]   corrupt_q;
	logic [CNT_W-1:0]   healthy_q;
	logic [CNT_W-1:0]   reloc_q;
	logic               seen_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ERASE_W-1:0] low_q;
	logic [ERASE_W-1:0] high_q;
	logic               fault_q;

	logic               full;
	logic               healthy;
	logic               bad_code;
	logic [ERASE_W-1:0] gap;

	assign full = (idx_q == FULL_IDX);
	assign gap  = high_q - rd_data_s1[ERASE_W-1:0];

	assign status.scan_end = (scan_addr_q == idx_q - IDX_W'(1));
	assign status.out_busy = out_valid && out_stall;

	always_comb begin
		healthy  = 1'b1;
		bad_code = 1'b0;
		unique case (block_state)
			BS_FREE, BS_RECLAIM, BS_CORRUPT, BS_MAPPED: begin
				healthy = 1'b1;
			end
			BS_UNKNOWN, BS_BAD, BS_WORN: begin
				healthy = 1'b0;
			end
			default: begin
				healthy  = 1'b0;
				bad_code = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_thr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !full) begin
			mem[idx_q[AW-1:0]] <= {block_state == BS_MAPPED, erase_cnt};
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= mem[scan_addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			free_q    <= '0;
			reclaim_q <= '0;
			bad_q     <= '0;
			corrupt_q <= '0;
			healthy_q <= '0;
			seen_q    <= 1'b0;
			sum_q     <= '0;
			low_q     <= '1;
			high_q    <= '0;
			fault_q   <= 1'b0;
		end else if (cmd.publish) begin
			idx_q     <= '0;
			free_q    <= '0;
			reclaim_q <= '0;
			bad_q     <= '0;
			corrupt_q <= '0;
			healthy_q <= '0;
			seen_q    <= 1'b0;
			sum_q     <= '0;
			low_q     <= '1;
			high_q    <= '0;
			fault_q   <= 1'b0;
		end else if (cmd.take) begin
			if (full) begin
				fault_q <= 1'b1;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				if (bad_code) begin
					fault_q <= 1'b1;
				end
				if (block_state == BS_FREE) begin
					free_q <= free_q + CNT_W'(1);
				end
				if (block_state == BS_UNKNOWN || block_state == BS_RECLAIM) begin
					reclaim_q <= reclaim_q + CNT_W'(1);
				end
				if (block_state == BS_BAD || block_state == BS_WORN) begin
					bad_q <= bad_q + CNT_W'(1);
				end
				if (block_state == BS_CORRUPT) begin
					corrupt_q <= corrupt_q + CNT_W'(1);
				end
				if (healthy) begin
					healthy_q <= healthy_q + CNT_W'(1);
					seen_q    <= 1'b1;
					sum_q     <= sum_q + {{(SUM_W-ERASE_W){1'b0}}, erase_cnt};
					if (erase_cnt < low_q) begin
						low_q <= erase_cnt;
					end
					if (erase_cnt > high_q) begin
						high_q <= erase_cnt;
					end
				end
			end
		end
	end

	// relocation scan, one stored entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			reloc_q     <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.publish) begin
				scan_addr_q <= '0;
				reloc_q     <= '0;
			end else begin
				if (cmd.scan_rd) begin
					scan_addr_q <= scan_addr_q + IDX_W'(1);
				end
				if (rd_vld_s1 && rd_data_s1[ERASE_W] && (gap > thr_q)) begin
					reloc_q <= reloc_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.publish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			free_count        <= free_q;
			reclaimable_count <= reclaim_q;
			bad_count         <= bad_q;
			corrupt_count     <= corrupt_q;
			healthy_count     <= healthy_q;
			relocatable_count <= reloc_q;
			total_erase       <= sum_q;
			min_erase         <= seen_q ? low_q : '0;
			max_erase         <= seen_q ? high_q : '0;
			fault             <= fault_q;
		end
	end

endmodule

`default_nettype wire

@@ sv/flash_block_wear_statistics.sv @@
// flash_block_wear_statistics: top level, joins fbws_ctrl and fbws_dp
// depends on fbws_pkg, fbws_ctrl, fbws_dp
//
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall  block_state, erase_cnt, last_block
// out       source     out_valid / out_stall  counts, total_erase, min/max, fault
// cfg       sink       cfg_valid / cfg_ready  wear_threshold
//
// one block item is taken per cycle while a table loads
// after the last item the single-port block store is walked, one entry per cycle:
// each read is registered, a flush state lets the last read count, then the result is loaded
// the result waits in an output register; loading of the next table starts with it
// a second result waits for the first to be taken; input stalls meanwhile
// reset needs no clearing pass, cfg_ready is always high
`default_nettype none

module flash_block_wear_statistics #(
	parameter int MAX_BLOCKS = fbws_pkg::DEF_MAX_BLOCKS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [fbws_pkg::ERASE_W-1:0]      wear_threshold,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [fbws_pkg::STATE_W-1:0]      block_state,
	input  wire [fbws_pkg::ERASE_W-1:0]      erase_cnt,
	input  wire                              last_block,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [fbws_pkg::CNT_W-1:0]       free_count,
	output logic [fbws_pkg::CNT_W-1:0]       reclaimable_count,
	output logic [fbws_pkg::CNT_W-1:0]       bad_count,
	output logic [fbws_pkg::CNT_W-1:0]       corrupt_count,
	output logic [fbws_pkg::CNT_W-1:0]       healthy_count,
	output logic [fbws_pkg::CNT_W-1:0]       relocatable_count,
	output logic [fbws_pkg::SUM_W-1:0]       total_erase,
	output logic [fbws_pkg::ERASE_W-1:0]     min_erase,
	output logic [fbws_pkg::ERASE_W-1:0]     max_erase,
	output logic                             fault
);
	import fbws_pkg::*;

	fbws_cmd_t    cmd;
	fbws_status_t status;

	assign cfg_ready = 1'b1;

	fbws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_block (last_block),
		.in_stall   (in_stall),
		.status     (status),
		.cmd        (cmd)
	);

	fbws_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_thr           (wear_threshold),
		.block_state       (block_state),
		.erase_cnt         (erase_cnt),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.free_count        (free_count),
		.reclaimable_count (reclaimable_count),
		.bad_count         (bad_count),
		.corrupt_count     (corrupt_count),
		.healthy_count     (healthy_count),
		.relocatable_count (relocatable_count),
		.total_erase       (total_erase),
		.min_erase         (min_erase),
		.max_erase         (max_erase),
		.fault             (fault)
	);

endmodule

`default_nettype wire

@@ sv/fbws_checker.sv @@
// fbws_checker: port-level assertions for flash_block_wear_statistics
// depends on fbws_pkg; bound to the top level at the end of this file
`default_nettype none

module fbws_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_stall,
	input wire                          last_block,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire [fbws_pkg::ERASE_W-1:0]  min_erase,
	input wire [fbws_pkg::ERASE_W-1:0]  max_erase
);
	import fbws_pkg::*;

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_erase <= max_erase)
		else $error("min_erase above max_erase");

	// closing transaction starts the scan, which holds off input
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_block |=> in_stall)
		else $error("input taken right after the last block");

	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a scan");

endmodule

bind flash_block_wear_statistics fbws_checker u_fbws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_block (last_block),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.min_erase  (min_erase),
	.max_erase  (max_erase)
);

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for flash_block_wear_statistics, one summary check per block table
// depends on fbws_pkg and the flash_block_wear_statistics rtl; needs no other files
// a scoreboard class predicts each table summary while plain tasks drive the ports
module tb;
	import fbws_pkg::*;

	localparam int MAX_BLOCKS  = DEF_MAX_BLOCKS;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [CNT_W-1:0]   free_count;
		logic [CNT_W-1:0]   reclaimable_count;
		logic [CNT_W-1:0]   bad_count;
		logic [CNT_W-1:0]   corrupt_count;
		logic [CNT_W-1:0]   healthy_count;
		logic [CNT_W-1:0]   relocatable_count;
		logic [SUM_W-1:0]   total_erase;
		logic [ERASE_W-1:0] min_erase;
		logic [ERASE_W-1:0] max_erase;
		logic               fault;
	} wear_summary_t;

	typedef enum int {
		MIX_UNIFORM,
		MIX_CLUSTER,
		MIX_EXTREME
	} count_mix_t;

	class wear_scoreboard;
		logic [ERASE_W-1:0] threshold;
		int unsigned        stored;
		logic [CNT_W-1:0]   free_n, reclaim_n, bad_n, corrupt_n, healthy_n;
		logic [SUM_W-1:0]   erase_total;
		logic [ERASE_W-1:0] erase_lo, erase_hi;
		logic               fault_seen;
		logic [ERASE_W-1:0] mapped_counts[$];
		wear_summary_t      expected_q[$];
		int unsigned        mismatches;
		int unsigned        summaries_checked;

		function new();
			threshold = THR_RESET;
			mismatches = 0;
			summaries_checked = 0;
			clear_table();
		endfunction

		function void clear_table();
			stored = 0;
			free_n = '0;
			reclaim_n = '0;
			bad_n = '0;
			corrupt_n = '0;
			healthy_n = '0;
			erase_total = '0;
			erase_lo = '1;
			erase_hi = '0;
			fault_seen = 1'b0;
			mapped_counts.delete();
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void account_block(input logic [STATE_W-1:0] st,
			input logic [ERASE_W-1:0] cnt, input logic last);
			logic               healthy;
			logic [ERASE_W-1:0] gap;
			wear_summary_t      s;
			if (stored >= MAX_BLOCKS) begin
				// table overflow, only the fault and the last mark matter
				fault_seen = 1'b1;
			end else begin
				healthy = 1'b1;
				case (st)
				BS_FREE: free_n++;
				BS_UNKNOWN: begin
					reclaim_n++;
					healthy = 1'b0;
				end
				BS_RECLAIM: reclaim_n++;
				BS_BAD, BS_WORN: begin
					bad_n++;
					healthy = 1'b0;
				end
				BS_CORRUPT: corrupt_n++;
				BS_MAPPED: mapped_counts.push_back(cnt);
				default: begin
					fault_seen = 1'b1;
					healthy = 1'b0;
				end
				endcase
				stored++;
				if (healthy) begin
					healthy_n++;
					erase_total = erase_total + SUM_W'(cnt);
					if (cnt < erase_lo) erase_lo = cnt;
					if (cnt > erase_hi) erase_hi = cnt;
				end
			end
			if (last) begin
				s.relocatable_count = '0;
				foreach (mapped_counts[i]) begin
					gap = erase_hi - mapped_counts[i];
					if (gap > threshold) s.relocatable_count = s.relocatable_count + 1'b1;
				end
				s.free_count = free_n;
				s.reclaimable_count = reclaim_n;
				s.bad_count = bad_n;
				s.corrupt_count = corrupt_n;
				s.healthy_count = healthy_n;
				s.total_erase = erase_total;
				s.min_erase = (healthy_n != 0) ? erase_lo : '0;
				s.max_erase = (healthy_n != 0) ? erase_hi : '0;
				s.fault = fault_seen;
				expected_q.push_back(s);
				clear_table();
			end
		endfunction

		function void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
			if (want !== seen) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in summary %0d, %s: expected %0h, got %0h",
						summaries_checked, name, want, seen);
			end
		endfunction

		function void check_summary(input wear_summary_t got);
			wear_summary_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("summary transaction with none pending: healthy %0d fault %0b",
						got.healthy_count, got.fault);
				return;
			end
			e = expected_q.pop_front();
			summaries_checked++;
			compare_field("free_count", e.free_count, got.free_count);
			compare_field("reclaimable_count", e.reclaimable_count, got.reclaimable_count);
			compare_field("bad_count", e.bad_count, got.bad_count);
			compare_field("corrupt_count", e.corrupt_count, got.corrupt_count);
			compare_field("healthy_count", e.healthy_count, got.healthy_count);
			compare_field("relocatable_count", e.relocatable_count, got.relocatable_count);
			compare_field("total_erase", e.total_erase, got.total_erase);
			compare_field("min_erase", e.min_erase, got.min_erase);
			compare_field("max_erase", e.max_erase, got.max_erase);
			compare_field("fault", e.fault, got.fault);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ERASE_W-1:0] wear_threshold = THR_RESET;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [STATE_W-1:0] block_state = BS_FREE;
	logic [ERASE_W-1:0] erase_cnt = '0;
	logic               last_block = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CNT_W-1:0]   free_count, reclaimable_count, bad_count, corrupt_count;
	logic [CNT_W-1:0]   healthy_count, relocatable_count;
	logic [SUM_W-1:0]   total_erase;
	logic [ERASE_W-1:0] min_erase, max_erase;
	logic               fault;

	wear_scoreboard sb = new();

	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned blocks_sent = 0;
	int unsigned thresholds_written = 0;
	int unsigned holds_done = 0;

	flash_block_wear_statistics #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.wear_threshold(wear_threshold),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.block_state(block_state),
		.erase_cnt(erase_cnt),
		.last_block(last_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.free_count(free_count),
		.reclaimable_count(reclaimable_count),
		.bad_count(bad_count),
		.corrupt_count(corrupt_count),
		.healthy_count(healthy_count),
		.relocatable_count(relocatable_count),
		.total_erase(total_erase),
		.min_erase(min_erase),
		.max_erase(max_erase),
		.fault(fault)
	);

	always #4 clk = ~clk;

	task automatic send_block(input logic [STATE_W-1:0] st, input logic [ERASE_W-1:0] cnt,
		input logic last);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_state <= st;
		erase_cnt <= cnt;
		last_block <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.account_block(st, cnt, last);
		blocks_sent++;
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [ERASE_W-1:0] value);
		wear_threshold <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.threshold = value;
		thresholds_written++;
	endtask

	function automatic logic [STATE_W-1:0] pick_state();
		int unsigned r;
		r = $urandom_range(0, 31);
		if (r < 11) return BS_MAPPED;
		if (r < 30) return STATE_W'($urandom_range(0, 5));
		return BS_INVALID;
	endfunction

	function automatic logic [ERASE_W-1:0] pick_count(input count_mix_t mix,
		input logic [ERASE_W-1:0] base, input logic [ERASE_W-1:0] spread);
		case (mix)
		MIX_CLUSTER: return base + $urandom_range(0, spread);
		MIX_EXTREME: begin
			case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return 32'hFFFF_FFFE;
			default: return $urandom;
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	// whole tables of random length, so every phase ends idle
	task automatic run_tables(input int unsigned target);
		int unsigned        sent;
		int unsigned        len;
		count_mix_t         mix;
		logic [ERASE_W-1:0] base;
		logic [ERASE_W-1:0] spread;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
			if ($urandom_range(0, 3) == 0) mix = MIX_UNIFORM;
			else if ($urandom_range(0, 4) == 0) mix = MIX_EXTREME;
			else mix = MIX_CLUSTER;
			base = $urandom;
			spread = (sb.threshold > 32'h0100_0000) ? 32'hFFFF_FFFF : sb.threshold * 2 + 32'd16;
			for (int i = 0; i < len; i++)
				send_block(pick_state(), pick_count(mix, base, spread), i == len - 1);
			sent += len;
		end
	endtask

	initial begin : sink
		int unsigned   stall_left;
		wear_summary_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				got.free_count = free_count;
				got.reclaimable_count = reclaimable_count;
				got.bad_count = bad_count;
				got.corrupt_count = corrupt_count;
				got.healthy_count = healthy_count;
				got.relocatable_count = relocatable_count;
				got.total_erase = total_erase;
				got.min_erase = min_erase;
				got.max_erase = max_erase;
				got.fault = fault;
				sb.check_summary(got);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				// long hold-off so the result path backs up into the input
				hold_request = 1'b0;
				holds_done++;
				stall_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// directed tables at the reset threshold
		send_block(BS_FREE, '0, 1'b1);
		send_block(BS_UNKNOWN, '1, 1'b1);
		send_block(BS_MAPPED, '1, 1'b0);
		send_block(BS_MAPPED, '0, 1'b0);
		send_block(BS_CORRUPT, 32'd5, 1'b0);
		send_block(BS_RECLAIM, 32'd7, 1'b0);
		send_block(BS_BAD, 32'd3, 1'b0);
		send_block(BS_WORN, 32'd9, 1'b0);
		send_block(BS_INVALID, 32'd1, 1'b0);
		send_block(BS_FREE, 32'd100, 1'b1);
		// gaps of exactly the threshold and one above it
		send_block(BS_MAPPED, 32'd10000, 1'b0);
		send_block(BS_MAPPED, 32'd5904, 1'b0);
		send_block(BS_MAPPED, 32'd5903, 1'b0);
		send_block(BS_FREE, 32'd10000, 1'b1);
		send_block(BS_FREE, 32'h8000_0000, 1'b0);
		send_block(BS_UNKNOWN, 32'h7FFF_FFFF, 1'b0);
		send_block(BS_RECLAIM, 32'h5555_5555, 1'b0);
		send_block(BS_BAD, 32'hAAAA_AAAA, 1'b0);
		send_block(BS_WORN, 32'h0000_FFFF, 1'b0);
		send_block(BS_CORRUPT, 32'hFFFF_0000, 1'b0);
		send_block(BS_MAPPED, 32'h0000_0001, 1'b0);
		send_block(BS_INVALID, 32'hFFFF_FFFE, 1'b1);
		drain_output();

		write_threshold('0);
		run_tables(300);
		drain_output();

		write_threshold('1);
		hold_request = 1'b1;
		run_tables(300);
		drain_output();

		write_threshold(ERASE_W'($urandom_range(1, 5000)));
		run_tables(200);
		drain_output();
		run_tables(200);
		drain_output();

		write_threshold($urandom);
		run_tables(300);
		drain_output();

		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_threshold(ERASE_W'($urandom_range(0, 20000)));
		run_tables(300);
		drain_output();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d block transactions in %0d checked tables, %0d threshold writes",
			blocks_sent, sb.summaries_checked, thresholds_written);
		$display("%0d long output hold-offs, %0d mismatches, %0d summaries left pending",
			holds_done, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

@@ files.f @@
sv/fbws_pkg.sv
sv/fbws_ctrl.sv
sv/fbws_dp.sv
sv/flash_block_wear_statistics.sv
sv/fbws_checker.sv
tb/tb.sv
